[src/quoted_token_scanner_assert.svh]
// Assertion macros shared by the token scanner RTL.
// Each macro checks a property on the rising edge of clk, disabled while rst is high.
`ifndef QUOTED_TOKEN_SCANNER_ASSERT_SVH
`define QUOTED_TOKEN_SCANNER_ASSERT_SVH

// A condition that must hold on every clock edge outside reset.
`define QTS_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("qts assertion failed: condition");

// A consequent that must hold in the cycle after the antecedent.
`define QTS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qts assertion failed: next-cycle implication");

`endif

[src/qts_pkg.sv]
// Shared types, codes and helpers for the quoted token scanner.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package qts_pkg;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Special characters.
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SPACE_LOW  = 2'd0;
  localparam logic [1:0] REG_SPACE_HIGH = 2'd1;
  localparam logic [1:0] REG_DELIM_LOW  = 2'd2;
  localparam logic [1:0] REG_DELIM_HIGH = 2'd3;

  typedef enum logic [2:0] {
    KIND_WORD_CHAR    = 3'd0,
    KIND_WORD_END     = 3'd1,
    KIND_DELIM        = 3'd2,
    KIND_COMMENT_CHAR = 3'd3,
    KIND_COMMENT_END  = 3'd4,
    KIND_QUOTE_ERR    = 3'd5,
    KIND_COMMENT_ERR  = 3'd6,
    KIND_DONE         = 3'd7
  } kind_t;

  // Character class masks, one bit per 7-bit code.
  typedef struct packed {
    logic [63:0] space_low;
    logic [63:0] space_high;
    logic [63:0] delim_low;
    logic [63:0] delim_high;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } result_t;

  // All results caused by one character, in emission order from slot 0.
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     slot;
  } entry_t;

  // Append one result to an entry.
  function automatic entry_t add_result(entry_t e, kind_t k, logic [7:0] ch);
    entry_t r;
    r = e;
    r.slot[r.count].kind = k;
    r.slot[r.count].ch = ch;
    r.count = r.count + 2'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

[src/quoted_token_scanner.sv]
// Quoted token scanner: accepts one character per beat on the slave stream and sends
// word, delimiter and comment tokens on the master stream. The slave side takes a
// character every cycle while the result queue (QueueDepth entries) has room; each
// character yields zero to three result beats, and the back end sends one per cycle
// while m_tready is high, so a run of characters that each cause one result or none
// keeps the full rate, and bursts of several results per character are absorbed by the
// queue. End of text is marked by s_tlast; the result beat that ends a character's
// results carries m_tlast. Whitespace and delimiter classes are set by four 64-bit
// registers at byte addresses 0, 8, 16 and 24, which the user must write only while
// the block is idle (unchecked). Depends on qts_pkg, qts_front, qts_queue and qts_back.
`default_nettype none

module quoted_token_scanner #(
  parameter int QueueDepth = qts_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  // Character stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,   // end_of_text
  // Token stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_char
  output logic [7:0]       m_tuser,   // [2:0] token_kind, [7:3] zero
  output logic             m_tlast    // run_last
);
  import qts_pkg::*;

  cfg_t   cfg;
  entry_t q_wr, q_rd;
  logic   q_push, q_pop, q_full, q_empty;
  logic   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Class registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (paddr[4:3])
        REG_SPACE_LOW:  cfg.space_low  <= pwdata;
        REG_SPACE_HIGH: cfg.space_high <= pwdata;
        REG_DELIM_LOW:  cfg.delim_low  <= pwdata;
        REG_DELIM_HIGH: cfg.delim_high <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:3])
      REG_SPACE_LOW:  prdata = cfg.space_low;
      REG_SPACE_HIGH: prdata = cfg.space_high;
      REG_DELIM_LOW:  prdata = cfg.delim_low;
      REG_DELIM_HIGH: prdata = cfg.delim_high;
      default:        prdata = '0;
    endcase
  end

  qts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr)
  );

  qts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  qts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_rd),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

[src/qts_front.sv]
// Front end: accepts characters, classifies them and tracks word, quote and comment state.
// Produces one queue entry holding every result of a character that has any; uses qts_pkg.
`default_nettype none

module qts_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire qts_pkg::cfg_t    cfg,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [7:0] char_code
  input  wire logic             s_tlast,   // end_of_text
  input  wire logic             q_full,
  output logic                  q_push,
  output qts_pkg::entry_t       q_data
);
  import qts_pkg::*;

  logic inside_word, inside_quote, inside_comment;
  logic inside_word_next, inside_quote_next, inside_comment_next;
  logic [7:0] c;
  logic [127:0] space_mask, delim_mask;
  logic is_space, is_delim, rescan, accept;
  entry_t ent;

  assign c = s_tdata;
  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;

  // Set membership; codes with the top bit set belong to neither set.
  assign space_mask = {cfg.space_high, cfg.space_low};
  assign delim_mask = {cfg.delim_high, cfg.delim_low};
  assign is_space = !c[7] && space_mask[c[6:0]];
  assign is_delim = !c[7] && delim_mask[c[6:0]];

  // Scan one character and collect its results.
  always_comb begin
    inside_word_next    = inside_word;
    inside_quote_next   = inside_quote;
    inside_comment_next = inside_comment;
    rescan = 1'b0;
    ent = '0;

    if (inside_comment) begin
      if (c == CH_CLOSE) begin
        ent = add_result(ent, KIND_COMMENT_END, 8'h00);
        inside_comment_next = 1'b0;
      end else begin
        ent = add_result(ent, KIND_COMMENT_CHAR, c);
      end
    end else if (inside_word) begin
      if (inside_quote) begin
        if (c == CH_QUOTE) begin
          inside_quote_next = 1'b0;
        end else begin
          ent = add_result(ent, KIND_WORD_CHAR, c);
        end
      end else if (c == CH_QUOTE) begin
        inside_quote_next = 1'b1;
      end else if (is_space || is_delim) begin
        ent = add_result(ent, KIND_WORD_END, 8'h00);
        inside_word_next = 1'b0;
        rescan = 1'b1;
      end else if (c == CH_OPEN) begin
        inside_comment_next = 1'b1;
      end else begin
        ent = add_result(ent, KIND_WORD_CHAR, c);
      end
    end else begin
      rescan = 1'b1;
    end

    // Outside a word with no quote or comment open.
    if (rescan) begin
      if (is_space) begin
        // Whitespace is skipped.
      end else if (is_delim) begin
        ent = add_result(ent, KIND_DELIM, c);
      end else if (c == CH_QUOTE) begin
        inside_word_next  = 1'b1;
        inside_quote_next = 1'b1;
      end else if (c == CH_OPEN) begin
        inside_comment_next = 1'b1;
      end else begin
        inside_word_next = 1'b1;
        ent = add_result(ent, KIND_WORD_CHAR, c);
      end
    end

    // End of text closes everything; an open quote or comment is an error.
    if (s_tlast) begin
      if (inside_quote_next) begin
        ent = add_result(ent, KIND_QUOTE_ERR, 8'h00);
      end else if (inside_comment_next) begin
        ent = add_result(ent, KIND_COMMENT_ERR, 8'h00);
      end else begin
        if (inside_word_next) begin
          ent = add_result(ent, KIND_WORD_END, 8'h00);
        end
        ent = add_result(ent, KIND_DONE, 8'h00);
      end
      inside_word_next    = 1'b0;
      inside_quote_next   = 1'b0;
      inside_comment_next = 1'b0;
    end
  end

  // Characters that cause no result leave nothing in the queue.
  assign q_push = accept && (ent.count != 2'd0);
  assign q_data = ent;

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word    <= 1'b0;
      inside_quote   <= 1'b0;
      inside_comment <= 1'b0;
    end else if (accept) begin
      inside_word    <= inside_word_next;
      inside_quote   <= inside_quote_next;
      inside_comment <= inside_comment_next;
    end
  end

endmodule

`default_nettype wire

[src/qts_queue.sv]
// Short queue of result entries between the front and back of the scanner.
// Register-based storage with a single read port at the head; uses qts_pkg.
`default_nettype none

module qts_queue #(
  parameter int Depth = qts_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire qts_pkg::entry_t wr_data,
  input  wire logic            pop,
  output qts_pkg::entry_t      rd_data,
  output logic                 full,
  output logic                 empty
);
  import qts_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/qts_back.sv]
// Back end: takes queue entries apart and sends their results one beat at a time.
// Owns the output register; uses qts_pkg and the assertion macros.
`default_nettype none

`include "quoted_token_scanner_assert.svh"

module qts_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire qts_pkg::entry_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,   // [7:0] out_char
  output logic [7:0]           m_tuser,   // [2:0] token_kind, [7:3] zero
  output logic                 m_tlast    // run_last
);
  import qts_pkg::*;

  logic [1:0] sel;
  logic       load, last_slot;
  result_t    cur;
  kind_t      kind_reg;
  logic [7:0] char_reg;

  assign cur       = head.slot[sel];
  assign last_slot = (sel == head.count - 2'd1);
  assign load      = head_valid && (!m_tvalid || m_tready);
  assign pop       = load && last_slot;

  // Output register; refills in the same cycle a beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= 2'd0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      sel      <= last_slot ? 2'd0 : sel + 2'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_reg <= cur.kind;
      char_reg <= cur.ch;
      m_tlast  <= last_slot;
    end
  end

  assign m_tdata = char_reg;
  assign m_tuser = {5'b00000, kind_reg};

  // The slot index stays within the head entry, and entries are never empty.
  `QTS_ASSERT_ALWAYS(a_sel_in_range, !head_valid || (sel < head.count))
  `QTS_ASSERT_ALWAYS(a_entry_not_empty, !head_valid || (head.count != 2'd0))
  // An entry only partly sent is still at the head next cycle.
  `QTS_ASSERT_NEXT(a_partial_entry_held, load && !last_slot, head_valid && (sel != 2'd0))

endmodule

`default_nettype wire
